// ===== rtl/core/cdrgb_pkg.sv =====
// Package for the color-difference to RGB converter.
// Holds fixed-point widths, Q16 coefficients, inter-stage structs and the Q6 clamp.
// No dependencies.
`default_nettype none

package cdrgb_pkg;

  // Sample formats
  localparam int SAMPLE_W = 16;        // signed Q6 input samples
  localparam int CHAN_W   = 14;        // clamped channel, unsigned Q6, 0..16320
  localparam int BYTE_W   = 8;
  localparam int DIFF_W   = 33;        // center*2^16 - weighted red/blue, signed Q22
  localparam int PROD_R_W = 29;        // red * 0.3 in Q22
  localparam int PROD_B_W = 27;        // blue * 0.11 in Q22

  // Q16 coefficients, rounded to nearest
  localparam logic [14:0] COEF_RED   = 15'd19661;   // 0.3
  localparam logic [12:0] COEF_BLUE  = 13'd7209;    // 0.11
  localparam logic [16:0] COEF_SCALE = 17'd111078;  // 1 / 0.59

  // 255.0 in Q6
  localparam logic [CHAN_W-1:0] MAX_Q6 = 14'd16320;

  // Stage 1 result: clamped red and blue plus the center sample
  typedef struct packed {
    logic [CHAN_W-1:0]          red;
    logic [CHAN_W-1:0]          blue;
    logic signed [SAMPLE_W-1:0] center;
    logic                       last;
  } chan_t;

  // Stage 3 result: unscaled green term and the finished red/blue bytes
  typedef struct packed {
    logic signed [DIFF_W-1:0] diff;
    logic [BYTE_W-1:0]        red_byte;
    logic [BYTE_W-1:0]        blue_byte;
    logic                     last;
  } diff_t;

  // Clamp a signed Q6 sum to 0..255.0
  function automatic logic [CHAN_W-1:0] clamp_q6(input logic signed [SAMPLE_W:0] v);
    logic [CHAN_W-1:0] res;
    if (v <= 0) begin
      res = '0;
    end else if (v >= $signed({3'b000, MAX_Q6})) begin
      res = MAX_Q6;
    end else begin
      res = v[CHAN_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cdrgb_clamp.sv =====
// Stage 1: forms red and blue as center plus difference, clamped to 0..255.0.
// Depends on cdrgb_pkg.
`default_nettype none

module cdrgb_clamp (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [cdrgb_pkg::SAMPLE_W-1:0] diff_red,
  input  wire logic signed [cdrgb_pkg::SAMPLE_W-1:0] center,
  input  wire logic signed [cdrgb_pkg::SAMPLE_W-1:0] diff_blue,
  input  wire logic                                last_pixel,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output cdrgb_pkg::chan_t                         out_chan
);
  import cdrgb_pkg::*;

  logic signed [SAMPLE_W:0] sum_red;
  logic signed [SAMPLE_W:0] sum_blue;

  // 17-bit sums cannot overflow
  assign sum_red  = {diff_red[SAMPLE_W-1], diff_red} + {center[SAMPLE_W-1], center};
  assign sum_blue = {diff_blue[SAMPLE_W-1], diff_blue} + {center[SAMPLE_W-1], center};

  assign in_ready = !out_valid || out_ready;

  // Stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_chan.red    <= clamp_q6(sum_red);
      out_chan.blue   <= clamp_q6(sum_blue);
      out_chan.center <= center;
      out_chan.last   <= last_pixel;
    end
  end

  a_red_range: assert property (@(posedge clk) disable iff (rst)
    (in_ready && in_valid) |=> (out_chan.red <= MAX_Q6 && out_chan.blue <= MAX_Q6))
    else $error("clamped channel out of range");

endmodule

`default_nettype wire

// ===== rtl/core/cdrgb_weight.sv =====
// Stages 2 and 3: weighs red by 0.3 and blue by 0.11, subtracts both from center.
// Depends on cdrgb_pkg.
`default_nettype none

module cdrgb_weight (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire cdrgb_pkg::chan_t in_chan,
  output logic           out_valid,
  input  wire logic      out_ready,
  output cdrgb_pkg::diff_t out_diff
);
  import cdrgb_pkg::*;

  // Stage 2 registers
  logic                  v2;
  logic [PROD_R_W-1:0]   prod_red;
  logic [PROD_B_W-1:0]   prod_blue;
  logic signed [SAMPLE_W-1:0] center2;
  logic [BYTE_W-1:0]     red_byte2;
  logic [BYTE_W-1:0]     blue_byte2;
  logic                  last2;
  logic                  ready2;

  logic signed [DIFF_W-1:0] diff_next;

  assign ready2   = !out_valid || out_ready;
  assign in_ready = !v2 || ready2;

  // Stage 2: the two products
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (in_ready) begin
      v2 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      prod_red   <= PROD_R_W'(in_chan.red * COEF_RED);
      prod_blue  <= PROD_B_W'(in_chan.blue * COEF_BLUE);
      center2    <= in_chan.center;
      red_byte2  <= in_chan.red[CHAN_W-1 -: BYTE_W];
      blue_byte2 <= in_chan.blue[CHAN_W-1 -: BYTE_W];
      last2      <= in_chan.last;
    end
  end

  // Stage 3: center in Q22 minus both products
  assign diff_next = $signed({center2[SAMPLE_W-1], center2, 16'd0})
                   - $signed({4'd0, prod_red})
                   - $signed({6'd0, prod_blue});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready2) begin
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2 && v2) begin
      out_diff.diff      <= diff_next;
      out_diff.red_byte  <= red_byte2;
      out_diff.blue_byte <= blue_byte2;
      out_diff.last      <= last2;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/cdrgb_green.sv =====
// Stages 4 and 5: scales the green term by 1/0.59 and clamps it to a byte.
// Depends on cdrgb_pkg.
`default_nettype none

module cdrgb_green (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire cdrgb_pkg::diff_t in_diff,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [cdrgb_pkg::BYTE_W-1:0] red_byte,
  output logic [cdrgb_pkg::BYTE_W-1:0] green_byte,
  output logic [cdrgb_pkg::BYTE_W-1:0] blue_byte,
  output logic             last_out
);
  import cdrgb_pkg::*;

  localparam int SCALED_W = DIFF_W + 18;
  localparam int FRAC_W   = 38;
  // 255.0 in Q38
  localparam logic signed [SCALED_W-1:0] G_SAT =
    $signed({{(SCALED_W - FRAC_W - BYTE_W){1'b0}}, 8'd255, {FRAC_W{1'b0}}});
  localparam logic signed [17:0] SCALE_S = $signed({1'b0, COEF_SCALE});

  // Stage 4 registers
  logic                       v4;
  logic signed [SCALED_W-1:0] scaled;
  logic [BYTE_W-1:0]          red_byte4;
  logic [BYTE_W-1:0]          blue_byte4;
  logic                       last4;
  logic                       ready4;
  logic [BYTE_W-1:0]          green_next;

  assign ready4   = !out_valid || out_ready;
  assign in_ready = !v4 || ready4;

  // Stage 4: scale to Q38
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (in_ready) begin
      v4 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      scaled     <= SCALED_W'(in_diff.diff * SCALE_S);
      red_byte4  <= in_diff.red_byte;
      blue_byte4 <= in_diff.blue_byte;
      last4      <= in_diff.last;
    end
  end

  // Stage 5: clamp and truncate green
  always_comb begin
    priority if (scaled <= 0) begin
      green_next = '0;
    end else if (scaled >= G_SAT) begin
      green_next = 8'd255;
    end else begin
      green_next = scaled[FRAC_W +: BYTE_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready4) begin
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (ready4 && v4) begin
      red_byte   <= red_byte4;
      green_byte <= green_next;
      blue_byte  <= blue_byte4;
      last_out   <= last4;
    end
  end

  a_green_zero: assert property (@(posedge clk) disable iff (rst)
    (ready4 && v4 && scaled <= 0) |=> (green_byte == '0))
    else $error("non-positive green not zeroed");

  a_green_sat: assert property (@(posedge clk) disable iff (rst)
    (ready4 && v4 && scaled >= G_SAT) |=> (green_byte == 8'd255))
    else $error("large green not saturated");

endmodule

`default_nettype wire

// ===== rtl/core/color_difference_to_rgb_top.sv =====
// Top level of the color-difference to RGB converter.
// Depends on cdrgb_pkg, cdrgb_clamp, cdrgb_weight and cdrgb_green.
`default_nettype none

// Converts one pixel per clock from a signed Q6 center sample and two color
// differences to three bytes: red and blue are center plus difference clamped
// to 0..255, green is (center - 0.3*red - 0.11*blue)/0.59 clamped to 0..255,
// all truncated. Throughput is one transaction per clock while the output is
// ready; data passes through five register stages (clamp, products, subtract,
// 1/0.59 scale, green clamp). Each stage holds its own valid bit and takes new
// data whenever it is empty or its successor moves, so bubbles are squeezed
// out under output backpressure. tlast travels with its pixel.
module color_difference_to_rgb_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // diff_red[15:0], center[31:16], diff_blue[47:32]
  input  wire logic        s_axis_tlast,   // last_pixel
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // red_byte[7:0], green_byte[15:8], blue_byte[23:16]
  output logic             m_axis_tlast    // last_out
);
  import cdrgb_pkg::*;

  logic  chan_valid;
  logic  chan_ready;
  chan_t chan;
  logic  diff_valid;
  logic  diff_ready;
  diff_t diff;
  logic [BYTE_W-1:0] red_byte;
  logic [BYTE_W-1:0] green_byte;
  logic [BYTE_W-1:0] blue_byte;

  // Stage 1
  cdrgb_clamp u_clamp (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .diff_red   ($signed(s_axis_tdata[15:0])),
    .center     ($signed(s_axis_tdata[31:16])),
    .diff_blue  ($signed(s_axis_tdata[47:32])),
    .last_pixel (s_axis_tlast),
    .out_valid  (chan_valid),
    .out_ready  (chan_ready),
    .out_chan   (chan)
  );

  // Stages 2 and 3
  cdrgb_weight u_weight (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (chan_valid),
    .in_ready  (chan_ready),
    .in_chan   (chan),
    .out_valid (diff_valid),
    .out_ready (diff_ready),
    .out_diff  (diff)
  );

  // Stages 4 and 5
  cdrgb_green u_green (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (diff_valid),
    .in_ready   (diff_ready),
    .in_diff    (diff),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .red_byte   (red_byte),
    .green_byte (green_byte),
    .blue_byte  (blue_byte),
    .last_out   (m_axis_tlast)
  );

  assign m_axis_tdata = {blue_byte, green_byte, red_byte};

  // A ready sink keeps every stage moving
  a_flow: assert property (@(posedge clk) disable iff (rst)
    m_axis_tready |-> (s_axis_tready && chan_ready && diff_ready))
    else $error("pipeline stalled with ready sink");

endmodule

`default_nettype wire

// ===== tb/cdrgb_pixel_check.sv =====
// Pixel checker for color_difference_to_rgb_top: watches both stream channels,
// predicts the RGB bytes of every accepted pixel and compares them in order.
// Standalone; needs no package or RTL source.
`timescale 1ns / 100ps

module cdrgb_pixel_check (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // diff_red[15:0], center[31:16], diff_blue[47:32]
  input  wire logic        s_axis_tlast,   // last_pixel
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [23:0] m_axis_tdata,   // red_byte[7:0], green_byte[15:8], blue_byte[23:16]
  input  wire logic        m_axis_tlast,   // last_out
  output int               errors,
  output int               pending,
  output int               results_done
);

  // Q16 weights and the Q6 full-scale value
  localparam longint RED_WEIGHT   = 19661;    // 0.3
  localparam longint BLUE_WEIGHT  = 7209;     // 0.11
  localparam longint GREEN_SCALE  = 111078;   // 1 / 0.59
  localparam longint CHAN_MAX_Q6  = 255 * 64;
  localparam longint GREEN_MAX_Q38 = longint'(255) <<< 38;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } pixel_rgb_t;

  pixel_rgb_t expected_pixels[$];
  pixel_rgb_t want;

  function automatic longint saturate_q6(input longint v);
    if (v <= 0) return 0;
    if (v >= CHAN_MAX_Q6) return CHAN_MAX_Q6;
    return v;
  endfunction

  // Red/blue are center plus difference; green is recovered from the luma term
  function automatic pixel_rgb_t rgb_from_color_diff(input logic signed [15:0] dr,
                                                     input logic signed [15:0] c,
                                                     input logic signed [15:0] db,
                                                     input logic last);
    pixel_rgb_t px;
    longint red_q6;
    longint blue_q6;
    longint luma_q22;
    longint green_q38;
    red_q6    = saturate_q6(longint'(c) + longint'(dr));
    blue_q6   = saturate_q6(longint'(c) + longint'(db));
    luma_q22  = longint'(c) * 65536 - red_q6 * RED_WEIGHT - blue_q6 * BLUE_WEIGHT;
    green_q38 = luma_q22 * GREEN_SCALE;
    px.red  = red_q6[13:6];
    px.blue = blue_q6[13:6];
    if (green_q38 <= 0) begin
      px.green = 8'd0;
    end else if (green_q38 >= GREEN_MAX_Q38) begin
      px.green = 8'd255;
    end else begin
      px.green = green_q38[45:38];
    end
    px.last = last;
    return px;
  endfunction

  // Predict on input transactions, compare on output transactions
  always @(posedge clk) begin
    if (rst) begin
      expected_pixels.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_pixels.push_back(rgb_from_color_diff(s_axis_tdata[15:0],
                                                      s_axis_tdata[31:16],
                                                      s_axis_tdata[47:32],
                                                      s_axis_tlast));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        results_done++;
        if (expected_pixels.size() == 0) begin
          $error("unexpected result transaction: data %h last %b",
                 m_axis_tdata, m_axis_tlast);
          errors++;
        end else begin
          want = expected_pixels.pop_front();
          if (m_axis_tdata[7:0] !== want.red) begin
            $error("red_byte: expected %0d, actual %0d", want.red, m_axis_tdata[7:0]);
            errors++;
          end
          if (m_axis_tdata[15:8] !== want.green) begin
            $error("green_byte: expected %0d, actual %0d", want.green, m_axis_tdata[15:8]);
            errors++;
          end
          if (m_axis_tdata[23:16] !== want.blue) begin
            $error("blue_byte: expected %0d, actual %0d", want.blue, m_axis_tdata[23:16]);
            errors++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("last_out: expected %0d, actual %0d", want.last, m_axis_tlast);
            errors++;
          end
        end
      end
    end
    pending = expected_pixels.size();
  end

endmodule

// ===== tb/tb.sv =====
// Testbench top for color_difference_to_rgb_top: drives pixel transactions with
// random gaps and output backpressure, and reports the verdict.
// Depends on cdrgb_pixel_check and the RTL.
`timescale 1ns / 100ps

module tb;

  localparam int RANDOM_PIXELS  = 1400;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int HOLD_AT_RESULT = 300;
  localparam int DRAIN_CYCLES   = 10;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;

  int errors;
  int pending;
  int results_done;
  int quiet_cycles;
  bit tx_steady;
  bit rx_steady;
  bit rx_held;

  color_difference_to_rgb_top DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  cdrgb_pixel_check u_pixel_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .errors        (errors),
    .pending       (pending),
    .results_done  (results_done)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // One pixel transaction, with random idle cycles ahead of it
  task automatic send_pixel(input int dr, input int c, input int db, input bit last);
    @(negedge clk);
    while (!tx_steady && $urandom_range(99) < 30) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {db[15:0], c[15:0], dr[15:0]};
    s_axis_tlast  = last;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Output side: random backpressure plus one long hold-off
  initial begin
    m_axis_tready = 1'b0;
    rx_held = 1'b0;
    forever begin
      @(negedge clk);
      if (!rst && !rx_held && results_done >= HOLD_AT_RESULT) begin
        rx_held = 1'b1;
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      m_axis_tready = rx_steady || ($urandom_range(99) >= 30);
    end
  end

  // Watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Stimulus and verdict
  initial begin
    int kind;
    int c;
    int dr;
    int db;
    int edge_val;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    tx_steady     = 1'b0;
    rx_steady     = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Field extremes, clamp edges and green limits
    send_pixel(-32768, -32768, -32768, 1'b0);
    send_pixel(32767, 32767, 32767, 1'b1);
    send_pixel(0, 0, 0, 1'b0);
    send_pixel(0, 16320, 0, 1'b0);
    send_pixel(1, 0, 1, 1'b1);
    send_pixel(-1, 0, -1, 1'b0);
    send_pixel(16319, 0, 16319, 1'b0);
    send_pixel(16321, 0, 16321, 1'b0);
    send_pixel(16320, 0, -16320, 1'b1);
    send_pixel(-32768, 32767, -32768, 1'b0);
    send_pixel(32767, -32768, 32767, 1'b0);
    send_pixel(32767, 0, -32768, 1'b1);
    send_pixel(8000, 100, 0, 1'b0);
    send_pixel(-64, 64, -64, 1'b0);
    send_pixel(-9600, 9600, -9600, 1'b0);
    send_pixel(-9700, 9700, -9700, 1'b1);
    send_pixel(-5000, 5000, 3000, 1'b0);
    send_pixel(2000, 6000, -1000, 1'b1);
    wait_drained();

    // Random pixels: mostly plausible images, some clamp edges, some raw noise
    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      if (i == 500) begin
        tx_steady = 1'b1;
        rx_steady = 1'b1;
      end
      if (i == 800) begin
        tx_steady = 1'b0;
        rx_steady = 1'b0;
      end
      if (i == 1000) wait_drained();
      kind = $urandom_range(99);
      if (kind < 65) begin
        c  = int'($urandom_range(17300)) - 500;
        dr = int'($urandom_range(16000)) - 8000;
        db = int'($urandom_range(16000)) - 8000;
      end else if (kind < 85) begin
        edge_val = ($urandom_range(1) == 0) ? 0 : 16320;
        c  = int'($urandom_range(16320));
        dr = edge_val - c + int'($urandom_range(6)) - 3;
        db = (($urandom_range(1) == 0) ? 0 : 16320) - c + int'($urandom_range(6)) - 3;
      end else begin
        c  = int'($urandom_range(65535)) - 32768;
        dr = int'($urandom_range(65535)) - 32768;
        db = int'($urandom_range(65535)) - 32768;
      end
      send_pixel(dr, c, db, $urandom_range(15) == 0);
    end
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
